[rtl/ksc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ksc_pkg;

   // Size of the cipher alphabet and the width of the fill count that indexes it.
   localparam int unsigned TABLE_SIZE = 26;
   localparam int unsigned FILL_W     = 5;

   localparam logic [7:0] LETTER_A = 8'h61;
   localparam logic [7:0] LETTER_Z = 8'h7A;

   // Request codes carried in the req_type field.
   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_KEY   = 2'd1,
      REQ_END   = 2'd2,
      REQ_TEXT  = 2'd3
   } req_code_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] in_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       not_ready;
   } rsp_payload_type;

endpackage : ksc_pkg

`default_nettype wire

[rtl/keyword_substitution_cipher.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake             Payload
// req_*      in         req_valid/req_stall   ksc_pkg::req_payload_type (req_type, in_byte)
// rsp_*      out        rsp_valid/rsp_stall   ksc_pkg::rsp_payload_type (out_byte, not_ready)
//
// Clear and text requests are handled in the idle state; a text request yields
// its response in the register at the next edge. A key byte is taken in the
// request cycle, which reads the slot memory, and the next cycle checks the
// byte and appends it to the alphabet.
// End of key starts a walk in which a single letter counter and seen compare
// walk the alphabet from z down to a; the walk stops early once the table
// holds 26 entries. No request is taken meanwhile.
// Reset (synchronous, active high) clears the fill count, the key-done flag and
// the response valid, and starts a pass that writes all 256 slot memory entries;
// the request channel stays stalled during that pass.
// A stalled response holds the request channel stalled until it is taken.

module keyword_substitution_cipher (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  ksc_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output ksc_pkg::rsp_payload_type rsp_data
);
   import ksc_pkg::*;

   typedef enum logic [1:0] {
      ST_WIPE,
      ST_IDLE,
      ST_KEY,
      ST_FILL
   } state_type;

   state_type           state_ff, state_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                done_ff, done_in;
   logic [FILL_W-1:0]   letter_ff, letter_in;
   logic [7:0]          key_ff, key_in;
   logic [7:0]          wipe_ff, wipe_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   // The cipher alphabet has no reset: every entry read is written first.
   logic [7:0]          table_ff [TABLE_SIZE];
   logic                tbl_we;
   logic [FILL_W-1:0]   tbl_addr;
   logic [7:0]          tbl_wdata;

   // For each byte value, the table slot it was last appended to as a key byte. A
   // byte has been seen in the current key when its slot lies below the fill count
   // and that slot still holds the byte, so a clear only has to reset the count.
   logic [FILL_W-1:0]   slot_mem [256];
   logic                slot_we;
   logic [7:0]          slot_waddr;
   logic [FILL_W-1:0]   slot_wdata;
   logic [7:0]          seen_raddr;
   logic [FILL_W-1:0]   slot_rd_ff;
   logic [7:0]          seen_byte;
   logic                seen_hit;

   logic                req_accept;
   logic                fill_full;
   logic [7:0]          fill_letter;
   logic [FILL_W-1:0]   text_idx;
   logic                text_is_lower;

   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   assign fill_full     = (fill_ff == FILL_W'(TABLE_SIZE));
   assign fill_letter   = LETTER_A + {3'b000, letter_ff};
   assign text_idx      = FILL_W'(req_data.in_byte - LETTER_A);
   assign text_is_lower = (req_data.in_byte >= LETTER_A) && (req_data.in_byte <= LETTER_Z);

   // The slot memory read is registered: the address is the byte that the next
   // cycle will check, either the incoming key byte or the next letter of the
   // walk.
   assign seen_raddr = (state_in == ST_FILL) ? (LETTER_A + {3'b000, letter_in})
                                             : req_data.in_byte;
   assign seen_byte  = (state_ff == ST_FILL) ? fill_letter : key_ff;
   assign seen_hit   = (slot_rd_ff < fill_ff) && (table_ff[slot_rd_ff] == seen_byte);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      done_in      = done_ff;
      letter_in    = letter_ff;
      key_in       = key_ff;
      wipe_in      = wipe_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      tbl_we       = 1'b0;
      tbl_addr     = fill_ff;
      tbl_wdata    = key_ff;
      slot_we      = 1'b0;
      slot_waddr   = key_ff;
      slot_wdata   = fill_ff;

      case (state_ff)
         ST_WIPE: begin
            // Every slot memory entry gets a defined value after reset.
            slot_we    = 1'b1;
            slot_waddr = wipe_ff;
            slot_wdata = '1;
            if (wipe_ff == 8'hFF) begin
               state_in = ST_IDLE;
            end else begin
               wipe_in = wipe_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_code_type'(req_data.req_type))
                  REQ_CLEAR: begin
                     fill_in = '0;
                     done_in = 1'b0;
                  end
                  REQ_KEY: begin
                     // Bytes after end of key and bytes beyond a full table are
                     // dropped here; repeats are found in the next cycle.
                     if (!done_ff && !fill_full) begin
                        state_in = ST_KEY;
                        key_in   = req_data.in_byte;
                     end
                  end
                  REQ_END: begin
                     if (!done_ff) begin
                        state_in  = ST_FILL;
                        letter_in = FILL_W'(TABLE_SIZE - 1);
                     end
                  end
                  REQ_TEXT: begin
                     rsp_valid_in          = 1'b1;
                     rsp_data_in.not_ready = !done_ff;
                     if (done_ff && text_is_lower) begin
                        rsp_data_in.out_byte = table_ff[text_idx];
                     end else begin
                        rsp_data_in.out_byte = req_data.in_byte;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_KEY: begin
            // A fresh byte takes the next slot and records where it went.
            if (!seen_hit) begin
               tbl_we  = 1'b1;
               slot_we = 1'b1;
               fill_in = fill_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_FILL: begin
            // One letter per cycle, from z down to a, into the free slots.
            if (fill_full) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               if (!seen_hit) begin
                  tbl_we    = 1'b1;
                  tbl_wdata = fill_letter;
                  fill_in   = fill_ff + 1'b1;
               end
               if (letter_ff == '0) begin
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  letter_in = letter_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         fill_ff      <= '0;
         done_ff      <= 1'b0;
         letter_ff    <= '0;
         key_ff       <= '0;
         wipe_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         done_ff      <= done_in;
         letter_ff    <= letter_in;
         key_ff       <= key_in;
         wipe_ff      <= wipe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_ff[tbl_addr] <= tbl_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rd_ff <= slot_mem[seen_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The fill count never passes the size of the alphabet.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(TABLE_SIZE))
      else $error("fill count beyond table size");

   // Once the key is finished, every table entry has been written.
   a_done_full: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> fill_full)
      else $error("key finished with free table slots");

   // Leaving the fill walk always marks the key as finished.
   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) && (state_in == ST_IDLE) |=> done_ff)
      else $error("fill walk ended without finishing the key");

   // A text request taken before the key is finished is answered flagged.
   a_early_text: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.req_type == REQ_TEXT) && !done_ff
      |=> rsp_valid && rsp_data.not_ready)
      else $error("early text not flagged");

endmodule : keyword_substitution_cipher

`default_nettype wire

[verif/keyword_substitution_cipher_tb.sv]
`timescale 1ns / 1ps

// Testbench for the keyword substitution cipher.
// A queue of pending requests feeds a driver that works on the falling edge, and a
// monitor on the rising edge records every accepted request and checks every
// accepted response. The monitor runs its own copy of the cipher: the seen-byte
// set, the alphabet table, the fill count and the key-done flag. Each accepted
// text request adds one expected response, which is compared field by field with
// the next response the block returns.

module keyword_substitution_cipher_tb;
   import ksc_pkg::*;

   // Cycles allowed after the last response. These cover an end-of-key walk that
   // may still be running, since that request never yields a response.
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned PHASE_REQUESTS = 300;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   keyword_substitution_cipher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // The idling percentages of the current phase. The driver reads the stall
   // percentage on every falling edge and the idle one when it may send.
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   req_payload_type pending_req [$];
   rsp_payload_type expected_rsp [$];
   int unsigned     request_count = 0;
   int unsigned     error_count   = 0;

   // This is set at the rising edge at which the block took the request on the
   // bus, so that the driver knows it may present the next one.
   logic req_taken = 1'b0;

   // The testbench's own copy of the cipher state.
   bit         seen_set [256];
   logic [7:0] cipher_alphabet [TABLE_SIZE];
   int unsigned fill_count = 0;
   bit          key_closed = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Move the cipher state on by one accepted request. A text request adds its
   // expected response to the queue.
   task automatic encipher_request(input req_payload_type item);
      rsp_payload_type rsp;
      int              letter;
      case (req_code_type'(item.req_type))
         REQ_CLEAR: begin
            foreach (seen_set[i]) seen_set[i] = 1'b0;
            fill_count = 0;
            key_closed = 1'b0;
         end
         REQ_KEY: begin
            // A byte is dropped if the key is closed, if the byte is a repeat or if
            // the table is full. A byte that is dropped because the table is full
            // is not marked as seen.
            if (!key_closed && !seen_set[item.in_byte] && fill_count < TABLE_SIZE) begin
               seen_set[item.in_byte] = 1'b1;
               cipher_alphabet[fill_count] = item.in_byte;
               fill_count++;
            end
         end
         REQ_END: begin
            // The free slots take the unused letters from z down to a.
            if (!key_closed) begin
               for (letter = LETTER_Z; letter >= LETTER_A; letter--) begin
                  if (fill_count < TABLE_SIZE && !seen_set[letter]) begin
                     cipher_alphabet[fill_count] = 8'(letter);
                     fill_count++;
                  end
               end
               key_closed = 1'b1;
            end
         end
         default: begin
            // Text sent before the key is closed passes unchanged and is flagged.
            // After that, only lowercase letters are looked up in the table.
            rsp.out_byte  = item.in_byte;
            rsp.not_ready = !key_closed;
            if (key_closed && item.in_byte >= LETTER_A && item.in_byte <= LETTER_Z) begin
               rsp.out_byte = cipher_alphabet[item.in_byte - LETTER_A];
            end
            expected_rsp.push_back(rsp);
         end
      endcase
   endtask

   // Driver. It presents a new request once the previous one has been taken, or
   // when the bus is idle. A request that is stalled stays on the bus unchanged.
   always @(negedge clock) begin
      rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_req.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor. The response check comes first. A response can never belong to a
   // request that is accepted at the same edge.
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            error_count++;
            $display("%0t: response with none expected: expected nothing, got %02h/%0b",
                     $time, rsp_data.out_byte, rsp_data.not_ready);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               error_count++;
               $display("%0t: out_byte mismatch: expected %02h, got %02h",
                        $time, want.out_byte, rsp_data.out_byte);
            end
            if (rsp_data.not_ready !== want.not_ready) begin
               error_count++;
               $display("%0t: not_ready mismatch: expected %0b, got %0b",
                        $time, want.not_ready, rsp_data.not_ready);
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         req_taken <= 1'b1;
         encipher_request(req_data);
      end else begin
         req_taken <= 1'b0;
      end
   end

   task automatic push_request(input req_code_type code, input logic [7:0] value);
      req_payload_type item;
      item.req_type = code;
      item.in_byte  = value;
      pending_req.push_back(item);
      request_count++;
   endtask

   function automatic logic [7:0] random_letter();
      return 8'(LETTER_A + $urandom_range(TABLE_SIZE - 1));
   endfunction

   // Directed requests: the byte extremes, every request code and each special
   // case of the key handling.
   task automatic directed_requests();
      int unsigned i;
      // Text before any key has been given.
      push_request(REQ_TEXT, 8'h00);
      push_request(REQ_TEXT, 8'hff);
      // A key with a repeated letter and non-letter bytes in it.
      push_request(REQ_KEY, "k");
      push_request(REQ_KEY, "e");
      push_request(REQ_KEY, "y");
      push_request(REQ_KEY, "e");
      push_request(REQ_KEY, 8'h00);
      push_request(REQ_KEY, 8'hff);
      push_request(REQ_TEXT, "q");
      push_request(REQ_END, 8'h00);
      // A second end of key and a key byte after the end must both be ignored.
      push_request(REQ_END, 8'hff);
      push_request(REQ_KEY, "x");
      push_request(REQ_TEXT, "a");
      push_request(REQ_TEXT, "z");
      push_request(REQ_TEXT, "k");
      push_request(REQ_TEXT, "A");
      push_request(REQ_TEXT, "Z");
      push_request(REQ_TEXT, 8'h60);
      push_request(REQ_TEXT, 8'h7b);
      // An empty key after a clear gives the reversed alphabet. This also shows
      // that the clear has emptied the seen set.
      push_request(REQ_CLEAR, 8'h00);
      push_request(REQ_END, 8'h00);
      push_request(REQ_TEXT, "a");
      // Twenty-eight distinct bytes: the last two find the table full and are
      // dropped.
      push_request(REQ_CLEAR, 8'hff);
      for (i = 0; i < TABLE_SIZE + 2; i++) push_request(REQ_KEY, 8'(8'h30 + i));
      push_request(REQ_END, 8'h00);
      push_request(REQ_TEXT, "a");
      push_request(REQ_TEXT, "z");
   endtask

   // Most sessions are well formed: a clear, a key, the end of the key and then
   // text. Some skip the clear, some send text in the middle of the key, and a
   // few are bursts of arbitrary requests.
   task automatic add_session();
      logic [7:0]  last_key;
      int unsigned key_len;
      int unsigned text_len;
      int unsigned i;
      last_key = random_letter();
      if ($urandom_range(9) == 0) begin
         for (i = 0; i < 8; i++) begin
            push_request(req_code_type'($urandom_range(3)), 8'($urandom_range(255)));
         end
         return;
      end
      if ($urandom_range(7) != 0) push_request(REQ_CLEAR, 8'($urandom));
      case ($urandom_range(9))
         0:       key_len = 0;
         1, 2:    key_len = $urandom_range(40, 20);
         default: key_len = $urandom_range(12, 1);
      endcase
      for (i = 0; i < key_len; i++) begin
         case ($urandom_range(9))
            0, 1:    last_key = 8'($urandom);
            2:       last_key = last_key;
            default: last_key = random_letter();
         endcase
         push_request(REQ_KEY, last_key);
         if ($urandom_range(19) == 0) push_request(REQ_TEXT, random_letter());
      end
      push_request(REQ_END, 8'($urandom));
      if ($urandom_range(7) == 0) push_request(REQ_END, 8'($urandom));
      text_len = $urandom_range(40, 8);
      for (i = 0; i < text_len; i++) begin
         push_request(REQ_TEXT, ($urandom_range(3) != 0) ? random_letter() : 8'($urandom));
      end
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned target;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      directed_requests();
      // The phases run with no idling, with the sender idle, with the receiver
      // stalling and with both at once.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         target = request_count + PHASE_REQUESTS;
         while (request_count < target) add_session();
         while (pending_req.size() != 0) @(posedge clock);
      end
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // A hang stops the run here. The limit is far above the slowest correct run.
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/ksc_pkg.sv
rtl/keyword_substitution_cipher.sv
verif/keyword_substitution_cipher_tb.sv
